@@ src/sbb_pkg.sv @@
// Package for the separable 3x3 box blur: shared types and fixed constants.
// Used by sbb_window, sbb_out_fifo and the top level; depends on nothing.
package sbb_pkg;

  // Configuration register width and address map
  localparam int CFG_W      = 13;
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Frame geometry limits
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = 12;
  localparam int MIN_SIZE   = 3;

  // Input word kinds (carried on in_tuser)
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Result queue sizing
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_CNT_W = 4;

  // Per-word control tag that travels down the pipeline
  typedef struct packed {
    logic vld;        // stage holds a word
    logic is_pix;     // pixel word (else drain tick)
    logic emit;       // word produces a first result
    logic two;        // word also produces the right-border result
    logic interior;   // first result is a real 3x3 average
    logic row_end;    // first result closes an output row
    logic frame_end;  // first result closes the frame
  } sbb_tag_t;

endpackage

@@ src/sbb_line_mem.sv @@
// Line memory for the box blur: one word per column holding the two previous rows.
// Single write port, single registered read port; uses no package items.
module sbb_line_mem #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 32
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/sbb_window.sv @@
// Window arithmetic for the box blur: column sums, 3x3 sum and rounded divide by 9.
// Depends on sbb_pkg for the pipeline tag type.
module sbb_window import sbb_pkg::*; #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sbb_tag_t              s1_tag,
  input  logic [PIXEL_BITS-1:0] s1_pix,
  input  logic [PIXEL_BITS-1:0] s1_row_a,
  input  logic [PIXEL_BITS-1:0] s1_row_b,
  output sbb_tag_t              s4_tag,
  output logic [PIXEL_BITS-1:0] s4_value
);

  localparam int CS_W    = PIXEL_BITS + 2;
  localparam int SUM_W   = PIXEL_BITS + 4;
  localparam int SHIFT   = SUM_W + 4;
  localparam int RECIP_W = SHIFT - 2;
  localparam int PROD_W  = SUM_W + RECIP_W;
  // ceil(2^SHIFT / 9): exact floor division by 9 for any SUM_W-bit dividend
  localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + 64'd8) / 64'd9;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  logic [CS_W-1:0]   cs_r [3];
  logic [CS_W-1:0]   col_sum;
  logic [SUM_W-1:0]  sum_nxt;
  logic [SUM_W-1:0]  sum_r;
  logic [PROD_W-1:0] prod_r;
  sbb_tag_t          tag2_r, tag3_r, tag4_r;

  assign col_sum = CS_W'(s1_row_a) + CS_W'(s1_row_b) + CS_W'(s1_pix);

  // shift the column sums on pixel words only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r[0] <= '0;
      cs_r[1] <= '0;
      cs_r[2] <= '0;
    end else if (s1_tag.vld && s1_tag.is_pix) begin
      cs_r[0] <= cs_r[1];
      cs_r[1] <= cs_r[2];
      cs_r[2] <= col_sum;
    end
  end

  // rounding offset folded into the sum
  assign sum_nxt = SUM_W'(cs_r[0]) + SUM_W'(cs_r[1]) + SUM_W'(cs_r[2]) + SUM_W'(4);

  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    prod_r <= PROD_W'(sum_r) * PROD_W'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
      tag3_r <= '0;
      tag4_r <= '0;
    end else begin
      tag2_r <= s1_tag;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
    end
  end

  assign s4_tag   = tag4_r;
  assign s4_value = tag4_r.interior ? prod_r[SHIFT +: PIXEL_BITS] : '0;

endmodule

@@ src/sbb_out_fifo.sv @@
// Result queue for the box blur: takes up to two words a cycle, hands out one.
// Depends on sbb_pkg for depth and pointer widths.
module sbb_out_fifo import sbb_pkg::*; #(
  parameter int DATA_W = 19
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push0,
  input  logic [DATA_W-1:0] data0,
  input  logic              push1,
  input  logic [DATA_W-1:0] data1,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  logic [DATA_W-1:0]     ent_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [FIFO_PTR_W-1:0] wr_ptr_p1;
  logic                  pop;

  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (push0) begin
      ent_r[wr_ptr_r] <= data0;
    end
    if (push1) begin
      ent_r[wr_ptr_p1] <= data1;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push0) + FIFO_PTR_W'(push1);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
    cnt_nxt    = cnt_r + FIFO_CNT_W'(push0) + FIFO_CNT_W'(push1) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign out_valid = (cnt_r != '0);
  assign out_data  = ent_r[rd_ptr_r];

endmodule

@@ src/separable_box_blur_3x3.sv @@
// Top level of the separable 3x3 box blur: position counters, config registers, line
// memory, window arithmetic and result queue. Depends on sbb_pkg and its submodules.
//
// Usage:
//  - Input words arrive on in_t* in raster order. in_tuser = 0 carries a pixel in
//    in_tdata; in_tuser = 1 is a drain tick that emits one zero pixel of the bottom
//    output row. Send frame_width drain ticks after the last pixel of a frame.
//  - Results leave on out_t*: out_tdata holds the blurred pixel, out_tuser flags row
//    and frame end, out_tlast marks the last result of the input word that caused it.
//    Output runs one row and one column behind the input; border pixels are zero.
//  - frame_width and frame_height are written over the APB port at 0x0 and 0x4
//    (values are clamped to 3..MAX_WIDTH and 3..4096). Write them only while idle.
//  - Throughput: one input word per cycle, sustained while in_tready is high. A pixel
//    at the right edge gives two results and a pixel in column 0 gives none, so a row
//    averages one result per word and an always-ready receiver never throttles the input.
//  - Path: an accepted word passes the line memory read, the column-sum stage, the
//    3x3 sum stage, the reciprocal multiply and the queue write before out_tvalid
//    rises for its result.
//  - Stall: in_tready drops once the 8-entry result queue plus the results still
//    in the pipeline could not absorb another word; nothing is lost or repeated.
//  - Reset (rst_n low, synchronous) clears positions, column sums, the queue and
//    restores 512x512. Line memory contents are not cleared; stale data reaches only
//    rows 0 and 1, which give no result or a zero one, so no clearing pass is needed.
module separable_box_blur_3x3 import sbb_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]       in_tdata,   // [P-1:0] pixel_in, rest zero
  input  logic [0:0]                            in_tuser,   // [0] operation
  // result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((PIXEL_BITS+7)/8)*8-1:0]       out_tdata,  // [P-1:0] pixel_out, rest zero
  output logic [1:0]                            out_tuser,  // [0] row_end, [1] frame_end
  output logic                                  out_tlast,  // run_last
  // configuration
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]                 cfg_paddr,
  input  logic [31:0]                           cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int TDATA_W = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WCNT_W  = $clog2(MAX_WIDTH + 1);
  localparam int ENT_W   = PIXEL_BITS + 3;

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] width_r, height_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(512);
      height_r <= CFG_W'(512);
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_FRAME_WIDTH:  width_r  <= cfg_pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: height_r <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_FRAME_WIDTH:  cfg_prdata = 32'(width_r);
      REG_FRAME_HEIGHT: cfg_prdata = 32'(height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // clamp the sizes into their usable range
  logic [WCNT_W-1:0] w_eff, w_last;
  logic [CFG_W-1:0]  h_eff, h_last;

  always_comb begin
    if (width_r < CFG_W'(MIN_SIZE)) begin
      w_eff = WCNT_W'(MIN_SIZE);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WCNT_W'(MAX_WIDTH);
    end else begin
      w_eff = WCNT_W'(width_r);
    end
    if (height_r < CFG_W'(MIN_SIZE)) begin
      h_eff = CFG_W'(MIN_SIZE);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
    w_last = w_eff - 1'b1;
    h_last = h_eff - 1'b1;
  end

  // ---------------------------------------------------------------- stage 0
  logic [COL_W-1:0]      col_r, col_nxt, col_cur;
  logic [ROW_W-1:0]      row_r, row_nxt, row_cur;
  logic [COL_W-1:0]      drain_r, drain_nxt, drain_cur;
  logic                  accept, is_drain, wrap, col_last, drain_last;
  logic [1:0]            n_res;
  sbb_tag_t              tag0;
  logic [FIFO_CNT_W-1:0] rsv_r, rsv_nxt;
  logic                  pop;

  assign accept   = in_tvalid && in_tready;
  assign is_drain = (in_tuser[0] == OP_DRAIN);

  always_comb begin
    // a size change can leave the positions outside the frame: restart it
    wrap    = (WCNT_W'(col_r) >= w_eff) || (CFG_W'(row_r) >= h_eff);
    col_cur = wrap ? '0 : col_r;
    row_cur = wrap ? '0 : row_r;
    col_last = (WCNT_W'(col_cur) == w_last);

    drain_cur  = (WCNT_W'(drain_r) >= w_eff) ? '0 : drain_r;
    drain_last = (WCNT_W'(drain_cur) == w_last);

    col_nxt   = col_r;
    row_nxt   = row_r;
    drain_nxt = drain_r;
    tag0      = '0;
    n_res     = 2'd0;

    if (accept) begin
      tag0.vld = 1'b1;
      if (is_drain) begin
        tag0.emit      = 1'b1;
        tag0.row_end   = drain_last;
        tag0.frame_end = drain_last;
        n_res          = 2'd1;
        drain_nxt      = drain_last ? '0 : drain_cur + 1'b1;
      end else begin
        tag0.is_pix   = 1'b1;
        tag0.emit     = (row_cur != '0) && (col_cur != '0);
        tag0.two      = tag0.emit && col_last;
        tag0.interior = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
        n_res         = {tag0.two, tag0.emit && !tag0.two};
        if (col_last) begin
          col_nxt = '0;
          row_nxt = (CFG_W'(row_cur) == h_last) ? '0 : row_cur + 1'b1;
        end else begin
          col_nxt = col_cur + 1'b1;
          row_nxt = row_cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      drain_r <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      drain_r <= drain_nxt;
    end
  end

  // reserve queue room for every result still in flight
  assign rsv_nxt   = rsv_r + FIFO_CNT_W'(n_res) - FIFO_CNT_W'(pop);
  assign in_tready = (rsv_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsv_r <= '0;
    end else begin
      rsv_r <= rsv_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 1
  sbb_tag_t                tag1_r;
  logic [COL_W-1:0]        col1_r;
  logic [PIXEL_BITS-1:0]   pix1_r;
  logic [2*PIXEL_BITS-1:0] mem_rd, mem_wr;
  logic                    mem_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
    end else begin
      tag1_r <= tag0;
    end
  end

  always_ff @(posedge clk) begin
    col1_r <= col_cur;
    pix1_r <= in_tdata[PIXEL_BITS-1:0];
  end

  // memory word is {row r-1, row r-2}; write back {this row, row r-1}.
  // Consecutive pixels always hit different columns, so no forwarding.
  assign mem_we = tag1_r.vld && tag1_r.is_pix;
  assign mem_wr = {pix1_r, mem_rd[2*PIXEL_BITS-1:PIXEL_BITS]};

  sbb_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2 * PIXEL_BITS)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept && !is_drain),
    .rd_addr (col_cur),
    .rd_data (mem_rd),
    .wr_en   (mem_we),
    .wr_addr (col1_r),
    .wr_data (mem_wr)
  );

  // ---------------------------------------------------------------- stages 2..4
  sbb_tag_t              tag4;
  logic [PIXEL_BITS-1:0] value4;

  sbb_window #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_tag   (tag1_r),
    .s1_pix   (pix1_r),
    .s1_row_a (mem_rd[PIXEL_BITS-1:0]),
    .s1_row_b (mem_rd[2*PIXEL_BITS-1:PIXEL_BITS]),
    .s4_tag   (tag4),
    .s4_value (value4)
  );

  // ---------------------------------------------------------------- result queue
  logic [ENT_W-1:0] ent0, ent1, head;

  // entry layout: {run_last, frame_end, row_end, pixel}
  assign ent0 = {!tag4.two, tag4.frame_end, tag4.row_end, value4};
  assign ent1 = {1'b1, 1'b0, 1'b1, {PIXEL_BITS{1'b0}}};

  sbb_out_fifo #(
    .DATA_W (ENT_W)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (tag4.vld && tag4.emit),
    .data0     (ent0),
    .push1     (tag4.vld && tag4.two),
    .data1     (ent1),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (head)
  );

  assign pop       = out_tvalid && out_tready;
  assign out_tdata = TDATA_W'(head[PIXEL_BITS-1:0]);
  assign out_tuser = head[PIXEL_BITS +: 2];
  assign out_tlast = head[PIXEL_BITS+2];

endmodule

@@ src/sbb_checker.sv @@
// Port-level checks for the box blur result stream, bound to the top level.
// Depends only on the top-level port list and its TDATA_W localparam.
module sbb_checker #(
  parameter int TDATA_W = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata,
  input logic [1:0]         out_tuser,
  input logic               out_tlast
);

  // no result shows in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  // a frame end always closes a row
  a_frame_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("frame_end without row_end");

  // row ends are border pixels and close the word's run
  a_row_end_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata == '0) && out_tlast)
    else $error("row_end result not a final zero pixel");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind separable_box_blur_3x3 sbb_checker #(.TDATA_W(TDATA_W)) u_sbb_checker (.*);
